@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, off during reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// implication in the next cycle, off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// implication in the next cycle, checked through reset as well
`define ASSERT_NEXT_ALL(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/mkpsd_pkg.sv @@
// ---------------------------------------------------------------------------
// mkpsd_pkg
// Widths, register indexes and reset values of the keypad scanner.
// ---------------------------------------------------------------------------
package mkpsd_pkg;

   localparam int SAMPLE_W    = 8;
   localparam int DRIVE_W     = 8;
   localparam int KEY_MASK_W  = 32;
   localparam int CNT_W       = 4;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 4;

   typedef logic [SAMPLE_W-1:0]    sample_type;
   typedef logic [DRIVE_W-1:0]     drive_type;
   typedef logic [KEY_MASK_W-1:0]  key_mask_type;
   typedef logic [CNT_W-1:0]       count_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;

   localparam csr_index_type CSR_NUM_COLUMNS     = csr_index_type'(0);
   localparam csr_index_type CSR_PRESS_THRESHOLD = csr_index_type'(1);

   localparam csr_data_type NUM_COLUMNS_RESET     = csr_data_type'(5);
   localparam csr_data_type PRESS_THRESHOLD_RESET = csr_data_type'(2);

   localparam count_type COUNT_MAX  = '1;
   localparam drive_type DRIVE_NONE = '1;

endpackage

@@ rtl/mkpsd_if.sv @@
// ---------------------------------------------------------------------------
// mkpsd_req_if / mkpsd_rsp_if / mkpsd_csr_if
// Valid/ready channels of the keypad scanner.
// ---------------------------------------------------------------------------
interface mkpsd_req_if;
   logic                  valid;
   logic                  ready;
   mkpsd_pkg::sample_type row_sample_first;
   mkpsd_pkg::sample_type row_sample_second;

   modport source (output valid, output row_sample_first, output row_sample_second,
                   input ready);
   modport sink   (input valid, input row_sample_first, input row_sample_second,
                   output ready);
endinterface

interface mkpsd_rsp_if;
   logic                    valid;
   logic                    ready;
   mkpsd_pkg::drive_type    column_drive;
   logic                    scan_done;
   mkpsd_pkg::key_mask_type key_mask;

   modport source (output valid, output column_drive, output scan_done, output key_mask,
                   input ready);
   modport sink   (input valid, input column_drive, input scan_done, input key_mask,
                   output ready);
endinterface

interface mkpsd_csr_if;
   logic                     valid;
   logic                     ready;
   mkpsd_pkg::csr_index_type index;
   mkpsd_pkg::csr_data_type  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/matrix_keypad_scan_debounce.sv @@
// ---------------------------------------------------------------------------
// matrix_keypad_scan_debounce
// Column scanner for a key matrix with per-key debounce counters held in a
// row-per-column memory, and a pressed mask reported at the end of a pass.
// ---------------------------------------------------------------------------
//  channel  dir  payload                                  transfer
//  req      in   row_sample_first, row_sample_second      valid & ready
//  rsp      out  column_drive, scan_done, key_mask        valid & ready
//  csr      in   index, data                              valid (ready held high)
//
//  One item per cycle unless rsp stalls; results pass the update and output registers.
//  The counter memory is read in the transfer cycle and written back from the update stage;
//  an item on the column just written takes the written row by forwarding.
//  Reset clears the row valid bits at once; no clearing pass.
//  A held rsp stalls the update stage, which then holds req.ready low.
// ---------------------------------------------------------------------------
module matrix_keypad_scan_debounce #(
   parameter int ROWS        = 4,
   parameter int MAX_COLUMNS = 8
) (
   input  logic        clock,
   input  logic        reset,
   mkpsd_req_if.sink   req,
   mkpsd_rsp_if.source rsp,
   mkpsd_csr_if.sink   csr
);
   import mkpsd_pkg::*;

   localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int ROW_W = ROWS * CNT_W;
   localparam int IDX_W = 7;

   // configuration
   csr_data_type num_columns_ff;
   csr_data_type press_threshold_ff;

   // column sequencing
   logic [COL_W-1:0] column_index_ff;
   logic [3:0]       eff_cols;
   logic [3:0]       col_inc;
   logic             done0;
   logic [COL_W-1:0] next_col;
   drive_type        drive0;

   // update stage
   logic             s1_valid_ff;
   logic [COL_W-1:0] s1_col_ff;
   sample_type       s1_first_ff;
   sample_type       s1_second_ff;
   logic             s1_done_ff;
   drive_type        s1_drive_ff;

   // counter memory
   logic [ROW_W-1:0]       mem [MAX_COLUMNS];
   logic [MAX_COLUMNS-1:0] row_valid_ff;
   logic [ROW_W-1:0]       rd_data_ff;
   logic                   rd_valid_ff;

   logic [ROW_W-1:0] old_row;
   logic [ROW_W-1:0] new_row;
   key_mask_type     pressed_bits;
   key_mask_type     acc_ff;
   key_mask_type     acc_in;

   // output register
   logic         rsp_valid_ff;
   drive_type    rsp_drive_ff;
   logic         rsp_done_ff;
   key_mask_type rsp_mask_ff;

   logic accept;
   logic out_free;
   logic s1_adv;
   logic bypass;

   assign csr.ready = 1'b1;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req.ready = !s1_valid_ff || out_free;
   assign accept    = req.valid && req.ready;
   assign bypass    = s1_adv && (s1_col_ff == column_index_ff);

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.column_drive = rsp_drive_ff;
   assign rsp.scan_done    = rsp_done_ff;
   assign rsp.key_mask     = rsp_mask_ff;

   always_comb begin
      priority if (num_columns_ff == '0) begin
         eff_cols = 4'd1;
      end else if (num_columns_ff > 4'(MAX_COLUMNS)) begin
         eff_cols = 4'(MAX_COLUMNS);
      end else begin
         eff_cols = num_columns_ff;
      end
      col_inc  = 4'(column_index_ff) + 4'd1;
      done0    = (col_inc >= eff_cols);
      next_col = done0 ? '0 : COL_W'(col_inc);
      drive0   = ~(drive_type'(1) << next_col);
   end

   always_comb begin
      logic [IDX_W-1:0] idx;
      count_type        cnt;
      count_type        cnt_n;
      idx          = '0;
      cnt          = '0;
      cnt_n        = '0;
      old_row      = rd_valid_ff ? rd_data_ff : '0;
      new_row      = old_row;
      pressed_bits = '0;
      if (s1_first_ff == s1_second_ff) begin
         for (int r = 0; r < ROWS; r++) begin
            idx = IDX_W'(s1_col_ff) * IDX_W'(ROWS) + IDX_W'(r);
            cnt = old_row[r*CNT_W +: CNT_W];
            if (!s1_first_ff[r]) begin
               cnt_n = (cnt == COUNT_MAX) ? COUNT_MAX : cnt + count_type'(1);
               if (cnt_n >= press_threshold_ff && idx < IDX_W'(KEY_MASK_W)) begin
                  pressed_bits[idx[4:0]] = 1'b1;
               end
            end else begin
               cnt_n = '0;
            end
            new_row[r*CNT_W +: CNT_W] = cnt_n;
         end
      end
      acc_in = acc_ff | pressed_bits;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         num_columns_ff     <= NUM_COLUMNS_RESET;
         press_threshold_ff <= PRESS_THRESHOLD_RESET;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_NUM_COLUMNS: begin
               num_columns_ff <= csr.data;
            end
            CSR_PRESS_THRESHOLD: begin
               press_threshold_ff <= csr.data;
            end
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         column_index_ff <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         row_valid_ff    <= '0;
         acc_ff          <= '0;
      end else begin
         if (accept) begin
            column_index_ff <= next_col;
            s1_valid_ff     <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff            <= 1'b1;
            row_valid_ff[s1_col_ff] <= 1'b1;
            acc_ff                  <= s1_done_ff ? '0 : acc_in;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // capture item and read its row, forwarding a same-cycle write
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff    <= column_index_ff;
         s1_first_ff  <= req.row_sample_first;
         s1_second_ff <= req.row_sample_second;
         s1_done_ff   <= done0;
         s1_drive_ff  <= drive0;
         rd_data_ff   <= bypass ? new_row : mem[column_index_ff];
         rd_valid_ff  <= bypass ? 1'b1 : row_valid_ff[column_index_ff];
      end
   end

   // write back and load the output register
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         mem[s1_col_ff] <= new_row;
         rsp_drive_ff   <= s1_drive_ff;
         rsp_done_ff    <= s1_done_ff;
         rsp_mask_ff    <= s1_done_ff ? acc_in : '0;
      end
   end

endmodule

@@ rtl/mkpsd_checker.sv @@
// ---------------------------------------------------------------------------
// mkpsd_checker
// Port-level checks of the keypad scanner, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mkpsd_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input mkpsd_pkg::drive_type    rsp_column_drive,
   input logic                    rsp_scan_done,
   input mkpsd_pkg::key_mask_type rsp_key_mask
);
   import mkpsd_pkg::*;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_column_drive) && $stable(rsp_key_mask))
   `ASSERT_SAME(a_mask_only_done, clock, reset, rsp_valid && !rsp_scan_done, rsp_key_mask == '0)
   `ASSERT_SAME(a_drive_onehot, clock, reset, rsp_valid, $onehot(~rsp_column_drive))
   `ASSERT_SAME(a_done_restart, clock, reset, rsp_valid && rsp_scan_done, rsp_column_drive == (DRIVE_NONE ^ drive_type'(1)))
   `ASSERT_NEXT_ALL(a_reset_idle, clock, reset, !rsp_valid)

endmodule

bind matrix_keypad_scan_debounce mkpsd_checker u_mkpsd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_column_drive (rsp.column_drive),
   .rsp_scan_done    (rsp.scan_done),
   .rsp_key_mask     (rsp.key_mask)
);

@@ tb/tb_matrix_keypad_scan_debounce.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_matrix_keypad_scan_debounce
// Drives column reading pairs into the keypad scanner, predicts each column
// result with its own model of the debounce counters and pressed mask, and
// compares every rsp transfer field by field. Column count and threshold are
// reprogrammed between idle phases, including the extreme and
// out-of-range settings.
// ---------------------------------------------------------------------------
module tb_matrix_keypad_scan_debounce;
   import mkpsd_pkg::*;

   localparam int SCAN_ROWS     = 4;
   localparam int SCAN_COLS_MAX = 8;
   localparam int KEY_SLOTS     = 32;
   localparam int NUM_PHASES    = 12;
   localparam int PHASE_ITEMS   = 145;
   localparam csr_index_type CSR_INDEX_TOP = '1;

   typedef struct {
      sample_type first;
      sample_type second;
      logic       pause;
   } scan_item_type;

   typedef struct {
      drive_type    drive;
      logic         done;
      key_mask_type mask;
   } scan_result_type;

   logic clock = 1'b0;
   logic reset;

   mkpsd_req_if req_ch ();
   mkpsd_rsp_if rsp_ch ();
   mkpsd_csr_if csr_ch ();

   matrix_keypad_scan_debounce #(
      .ROWS        (SCAN_ROWS),
      .MAX_COLUMNS (SCAN_COLS_MAX)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   always #6 clock = ~clock;

   // scanner model state
   logic [2:0]   scan_col;
   count_type    key_count [KEY_SLOTS];
   key_mask_type held_mask;
   csr_data_type cols_cfg;
   csr_data_type thresh_cfg;

   scan_item_type   pending_scans [$];
   scan_result_type expected_scans [$];
   sample_type      held_rows [SCAN_COLS_MAX];
   int              mismatch_count = 0;
   logic            req_taken = 1'b0;
   int              burst_left = 8;
   int              gap_left = 0;
   int              stall_mode = 0;
   int              stall_left = 0;
   int              stall_tick = 0;

   function automatic int active_columns();
      if (cols_cfg == '0) return 1;
      if (int'(cols_cfg) > SCAN_COLS_MAX) return SCAN_COLS_MAX;
      return int'(cols_cfg);
   endfunction

   function automatic scan_result_type scan_column(sample_type first, sample_type second);
      scan_result_type res;
      int              slot;
      int              ncols;
      logic [3:0]      nxt;
      ncols = active_columns();
      if (first == second) begin
         for (int r = 0; r < SCAN_ROWS; r++) begin
            slot = int'(scan_col) * SCAN_ROWS + r;
            if (slot < KEY_SLOTS) begin
               if (!first[r]) begin
                  if (key_count[slot] != COUNT_MAX) key_count[slot] = key_count[slot] + 1'b1;
                  if (key_count[slot] >= thresh_cfg) held_mask[slot] = 1'b1;
               end else begin
                  key_count[slot] = '0;
               end
            end
         end
      end
      res.done  = (int'(scan_col) + 1 >= ncols);
      nxt       = res.done ? 4'd0 : 4'(scan_col) + 4'd1;
      scan_col  = nxt[2:0];
      res.drive = ~(drive_type'(1) << nxt);
      res.mask  = res.done ? held_mask : '0;
      if (res.done) held_mask = '0;
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= 50)
         $display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
   endtask

   task automatic push_scan(sample_type first, sample_type second, logic pause);
      scan_item_type item;
      item.first  = first;
      item.second = second;
      item.pause  = pause;
      pending_scans.push_back(item);
   endtask

   task automatic write_csr(csr_index_type index, csr_data_type data);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // hold until the sender is drained and every result is back
   task automatic settle();
      while (pending_scans.size() != 0 || req_ch.valid || expected_scans.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic queue_random_scans(int count);
      logic [2:0] col;
      int         ncols;
      int         pick;
      logic [3:0] upper;
      sample_type first;
      sample_type second;
      col   = scan_col;
      ncols = active_columns();
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 19) == 0) held_rows[col] = sample_type'($urandom);
         pick  = $urandom_range(0, 99);
         upper = 4'($urandom);
         first = {upper, held_rows[col][3:0]};
         if (pick < 80) begin
            second = first;
         end else if (pick < 92) begin
            second = first ^ sample_type'($urandom_range(1, 255));
         end else begin
            first  = sample_type'($urandom);
            second = sample_type'($urandom);
         end
         push_scan(first, second, (i == count / 2) || ($urandom_range(0, 99) == 0));
         col = (int'(col) + 1 >= ncols) ? 3'd0 : col + 3'd1;
      end
   endtask

   always @(negedge clock) begin : drive_scans
      scan_item_type nxt;
      logic          issue;
      issue = 1'b0;
      nxt   = '{default: '0};
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!(req_ch.valid && !req_taken)) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_scans.size() != 0 &&
                      !(pending_scans[0].pause && expected_scans.size() != 0)) begin
            issue = 1'b1;
            nxt   = pending_scans.pop_front();
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
         req_ch.valid <= issue;
         if (issue) begin
            req_ch.row_sample_first  <= nxt.first;
            req_ch.row_sample_second <= nxt.second;
         end
      end
   end

   always @(negedge clock) begin : stall_results
      logic ready;
      if (stall_left <= 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(16, 200);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
         0:       ready = 1'b1;
         1:       ready = 1'($urandom_range(0, 1));
         2:       ready = ($urandom_range(0, 3) == 0);
         default: ready = (stall_tick % 5) != 0;
      endcase
      rsp_ch.ready <= reset ? 1'b1 : ready;
   end

   always @(posedge clock) begin : watch_scans
      scan_result_type want;
      if (reset) begin
         req_taken  = 1'b0;
         scan_col   = '0;
         held_mask  = '0;
         cols_cfg   = NUM_COLUMNS_RESET;
         thresh_cfg = PRESS_THRESHOLD_RESET;
         foreach (key_count[i]) key_count[i] = '0;
      end else begin
         req_taken = req_ch.valid && req_ch.ready;
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_NUM_COLUMNS:     cols_cfg   = csr_ch.data;
               CSR_PRESS_THRESHOLD: thresh_cfg = csr_ch.data;
               default: ;
            endcase
         end
         if (req_taken)
            expected_scans.push_back(scan_column(req_ch.row_sample_first,
                                                 req_ch.row_sample_second));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_scans.size() == 0) begin
               report_mismatch("unexpected transfer", rsp_ch.key_mask, '0);
            end else begin
               want = expected_scans.pop_front();
               if (rsp_ch.column_drive !== want.drive)
                  report_mismatch("column_drive", 32'(rsp_ch.column_drive), 32'(want.drive));
               if (rsp_ch.scan_done !== want.done)
                  report_mismatch("scan_done", 32'(rsp_ch.scan_done), 32'(want.done));
               if (rsp_ch.key_mask !== want.mask)
                  report_mismatch("key_mask", rsp_ch.key_mask, want.mask);
            end
         end
      end
   end

   initial begin : run_scans
      int           cols_plan [8];
      int           thr_plan  [8];
      csr_data_type cols_next;
      csr_data_type thr_next;
      cols_plan                = '{1, 8, 0, 15, 3, 8, 5, 2};
      thr_plan                 = '{15, 1, 0, 15, 4, 0, 2, 9};
      req_ch.valid             = 1'b0;
      req_ch.row_sample_first  = '1;
      req_ch.row_sample_second = '1;
      rsp_ch.ready             = 1'b1;
      csr_ch.valid             = 1'b0;
      csr_ch.index             = '0;
      csr_ch.data              = '0;
      foreach (held_rows[i]) held_rows[i] = '1;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // idle pass, then two pressed passes with upper sample bits high in the second, then mixed and unequal pairs
      repeat (5) push_scan(8'hFF, 8'hFF, 1'b0);
      repeat (5) push_scan(8'h00, 8'h00, 1'b0);
      repeat (5) push_scan(8'hF0, 8'hF0, 1'b0);
      push_scan(8'h00, 8'h01, 1'b1);
      push_scan(8'h0A, 8'h0A, 1'b0);
      push_scan(8'h05, 8'h05, 1'b0);
      push_scan(8'hFF, 8'h7F, 1'b0);
      push_scan(8'h0F, 8'h0F, 1'b0);
      push_scan(8'hFE, 8'hFE, 1'b0);
      push_scan(8'h00, 8'h00, 1'b0);
      settle();

      for (int p = 0; p < NUM_PHASES; p++) begin
         cols_next = (p < 8) ? csr_data_type'(cols_plan[p]) : csr_data_type'($urandom_range(0, 15));
         thr_next  = (p < 8) ? csr_data_type'(thr_plan[p]) : csr_data_type'($urandom_range(0, 15));
         if ($urandom_range(0, 1)) begin
            write_csr(CSR_NUM_COLUMNS, cols_next);
            write_csr(CSR_PRESS_THRESHOLD, thr_next);
         end else begin
            write_csr(CSR_PRESS_THRESHOLD, thr_next);
            write_csr(CSR_NUM_COLUMNS, cols_next);
         end
         if (p == 0)
            write_csr(CSR_INDEX_TOP, csr_data_type'($urandom));
         else if ($urandom_range(0, 2) == 0)
            write_csr(csr_index_type'($urandom_range(2, 255)), csr_data_type'($urandom));
         queue_random_scans(PHASE_ITEMS);
         settle();
      end

      if (mismatch_count == 0) begin
         $display("matrix_keypad_scan_debounce verification clean");
      end else begin
         $display("matrix_keypad_scan_debounce verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("matrix_keypad_scan_debounce verification failed");
      $finish;
   end

endmodule
